>>> hdl/lwlm_pkg.sv
// Package with constants, types and the lock type classifier of the lock wait latency monitor.
package lwlm_pkg;

  localparam int NUM_CPUS = 8;
  localparam int PENDING_SLOTS = 64;
  localparam int NUM_TYPES = 9;
  localparam int CPU_W = 3;
  localparam int CPU_IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int SLOT_W = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_END = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [2:0] ST_BEGUN = 3'd0;
  localparam logic [2:0] ST_NESTED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_ENDED = 3'd3;
  localparam logic [2:0] ST_NOMATCH = 3'd4;
  localparam logic [2:0] ST_NEGATIVE = 3'd5;
  localparam logic [2:0] ST_READ = 3'd6;

  localparam logic [3:0] LT_PCPU_SPIN = 4'd0;
  localparam logic [3:0] LT_RW_READ = 4'd1;
  localparam logic [3:0] LT_RW_WRITE = 4'd2;
  localparam logic [3:0] LT_SPIN = 4'd3;
  localparam logic [3:0] LT_MUTEX = 4'd4;
  localparam logic [3:0] LT_RT_MUTEX = 4'd5;
  localparam logic [3:0] LT_RWSEM_READ = 4'd6;
  localparam logic [3:0] LT_RWSEM_WRITE = 4'd7;
  localparam logic [3:0] LT_OTHER = 4'd8;

  localparam int FLAG_SPIN = 0;
  localparam int FLAG_READ = 1;
  localparam int FLAG_WRITE = 2;
  localparam int FLAG_RT = 3;
  localparam int FLAG_PERCPU = 4;
  localparam int FLAG_MUTEX = 5;

  // Front to back command: a classified event with the lookup already done.
  typedef enum logic [2:0] {
    OP_REPLY,     // status only, nothing changes
    OP_CPU_BEGIN,
    OP_THR_BEGIN,
    OP_CPU_END,
    OP_THR_END,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [2:0]          status;
    logic [CPU_IDX_W-1:0] cpu;
    logic [SLOT_W-1:0]   slot;
    logic [31:0]         thread_id;
    logic [63:0]         lock_address;
    logic [31:0]         lock_flags;
    logic [63:0]         now_ns;
    logic [3:0]          type_select;
  } cmd_t;

  function automatic logic [3:0] type_of(input logic [31:0] f);
    logic [3:0] t;
    if (f[FLAG_SPIN]) begin
      if (f[FLAG_PERCPU]) t = LT_PCPU_SPIN;
      else if (f[FLAG_READ]) t = LT_RW_READ;
      else if (f[FLAG_WRITE]) t = LT_RW_WRITE;
      else t = LT_SPIN;
    end else if (f[FLAG_MUTEX]) t = LT_MUTEX;
    else if (f[FLAG_RT]) t = LT_RT_MUTEX;
    else if (f[FLAG_READ]) t = LT_RWSEM_READ;
    else if (f[FLAG_WRITE]) t = LT_RWSEM_WRITE;
    else if (f == 32'd0) t = LT_MUTEX;
    else t = LT_OTHER;
    return t;
  endfunction

endpackage

>>> hdl/lwlm_if.sv
// Channel interfaces for the event input and the result output.
interface lwlm_event_if import lwlm_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  cpu_index;
  logic [31:0] thread_id;
  logic [63:0] lock_address;
  logic [31:0] lock_flags;
  logic [63:0] now_ns;
  logic [3:0]  type_select;
  modport source(output valid, kind, cpu_index, thread_id, lock_address, lock_flags,
                 now_ns, type_select, input ready);
  modport sink(input valid, kind, cpu_index, thread_id, lock_address, lock_flags,
               now_ns, type_select, output ready);
endinterface

interface lwlm_result_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  lock_class;
  logic [63:0] total_time;
  logic [63:0] event_count;
  logic [63:0] max_time;
  modport source(output valid, status, lock_class, total_time, event_count, max_time,
                 input ready);
  modport sink(input valid, status, lock_class, total_time, event_count, max_time,
               output ready);
endinterface

>>> hdl/lwlm_front.sv
// Front end: owns the processor slots and the thread table, classifies each event.
module lwlm_front import lwlm_pkg::*; (
  input  logic clk,
  input  logic rst,
  lwlm_event_if.sink evt,
  input  logic  q_full,
  output logic  cmd_valid,
  output cmd_t  cmd
);

  logic [63:0] cpu_lock [NUM_CPUS];
  logic [NUM_CPUS-1:0] cpu_busy;
  logic [PENDING_SLOTS-1:0] thr_valid;
  logic [31:0] thr_key [PENDING_SLOTS];
  logic [63:0] thr_lock [PENDING_SLOTS];

  logic [CPU_IDX_W-1:0] cpu;
  logic cpu_ok, cpu_occ, hit, free_found;
  logic hit_busy, hit_same;
  logic [SLOT_W-1:0] hit_idx, free_idx;
  cmd_t c;
  logic accept;

  assign evt.ready = !q_full;
  assign accept = evt.valid && evt.ready;
  assign cpu = evt.cpu_index[CPU_IDX_W-1:0];
  assign cpu_ok = ({29'd0, evt.cpu_index} < NUM_CPUS);
  assign cpu_occ = cpu_ok && cpu_busy[cpu];

  // Match lines of the thread table and priority encoders for hit and free entry.
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    hit_busy = 1'b0;
    hit_same = 1'b0;
    free_found = 1'b0;
    free_idx = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (thr_valid[i] && thr_key[i] == evt.thread_id) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
        hit_busy = thr_lock[i] != 64'd0;
        hit_same = thr_lock[i] == evt.lock_address;
      end
      if (!thr_valid[i]) begin
        free_found = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    c = '0;
    c.op = OP_REPLY;
    c.cpu = cpu;
    c.thread_id = evt.thread_id;
    c.lock_address = evt.lock_address;
    c.lock_flags = evt.lock_flags;
    c.now_ns = evt.now_ns;
    c.type_select = evt.type_select;
    c.slot = hit ? hit_idx : free_idx;
    case (evt.kind)
      KIND_BEGIN: begin
        if (evt.lock_flags[FLAG_SPIN]) begin
          if (!cpu_ok) c.status = ST_FULL;
          else if (cpu_busy[cpu]) c.status = ST_NESTED;
          else begin
            c.op = OP_CPU_BEGIN;
            c.status = ST_BEGUN;
          end
        end else if (hit && hit_busy) begin
          c.status = ST_NESTED;
        end else if (!hit && !free_found) begin
          c.status = ST_FULL;
        end else begin
          c.op = OP_THR_BEGIN;
          c.status = ST_BEGUN;
        end
      end
      KIND_END: begin
        if (cpu_occ) begin
          if (cpu_lock[cpu] != evt.lock_address) c.status = ST_NOMATCH;
          else c.op = OP_CPU_END;
        end else if (!hit || !hit_same) begin
          c.status = ST_NOMATCH;
        end else begin
          c.op = OP_THR_END;
        end
      end
      default: begin
        c.op = OP_READ;
        c.status = ST_READ;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_busy <= '0;
      thr_valid <= '0;
      cmd_valid <= 1'b0;
    end else begin
      cmd_valid <= accept && evt.kind != KIND_UNUSED;
      cmd <= c;
      if (accept && evt.kind != KIND_UNUSED) begin
        case (c.op)
          OP_CPU_BEGIN: begin
            cpu_lock[cpu] <= evt.lock_address;
            cpu_busy[cpu] <= evt.lock_address != 64'd0;
          end
          OP_THR_BEGIN: begin
            thr_valid[c.slot] <= 1'b1;
            thr_key[c.slot] <= evt.thread_id;
            thr_lock[c.slot] <= evt.lock_address;
          end
          OP_CPU_END: cpu_busy[cpu] <= 1'b0;
          OP_THR_END: thr_valid[hit_idx] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> hdl/lwlm_queue.sv
// Two-entry command queue between the front and back ends.
module lwlm_queue import lwlm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_cmd,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t mem [QUEUE_DEPTH];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign out_valid = fill != 2'd0;
  assign out_cmd = mem[rd_ptr];
  assign pop = out_valid && out_ready;
  assign push = in_valid;
  // One place is held back for the command that is still in the front's output register after the handshake.
  assign full = fill != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= in_cmd;
        wr_ptr <= !wr_ptr;
      end
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(fill == 2'd2 && push && !pop)) else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !pop) else $error("command queue underflow");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("command queue fill out of range");
`endif

endmodule

>>> hdl/lwlm_back.sv
// Back end: start times and flags, duration, statistics update and the result register.
module lwlm_back import lwlm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  lwlm_result_if.source res
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_UPDATE, S_OUT} state_t;
  state_t state;

  logic [63:0] cpu_time [NUM_CPUS];
  logic [31:0] cpu_flags [NUM_CPUS];
  logic [63:0] thr_time [PENDING_SLOTS];
  logic [31:0] thr_flags [PENDING_SLOTS];
  logic [63:0] tot [NUM_TYPES];
  logic [63:0] cnt [NUM_TYPES];
  logic [63:0] mx [NUM_TYPES];

  logic [63:0] cpu_rd_time, thr_rd_time, now_q;
  logic [31:0] cpu_rd_flags, thr_rd_flags;
  logic from_cpu;

  logic [63:0] dur;
  logic [3:0] ty;
  logic [63:0] start;
  logic [31:0] fl;
  logic [3:0] sel;

  assign cmd_ready = state == S_IDLE;
  assign start = from_cpu ? cpu_rd_time : thr_rd_time;
  assign fl = from_cpu ? cpu_rd_flags : thr_rd_flags;
  assign sel = cmd.type_select;

  // Registered start time and flags of the command at the queue head, available in the next cycle.
  always_ff @(posedge clk) begin
    cpu_rd_time <= cpu_time[cmd.cpu];
    cpu_rd_flags <= cpu_flags[cmd.cpu];
    thr_rd_time <= thr_time[cmd.slot];
    thr_rd_flags <= thr_flags[cmd.slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res.valid <= 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
        tot[i] <= '0;
        cnt[i] <= '0;
        mx[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res.status <= cmd.status;
            res.lock_class <= '0;
            res.total_time <= '0;
            res.event_count <= '0;
            res.max_time <= '0;
            state <= S_OUT;
            case (cmd.op)
              OP_CPU_BEGIN: begin
                cpu_time[cmd.cpu] <= cmd.now_ns;
                cpu_flags[cmd.cpu] <= cmd.lock_flags;
              end
              OP_THR_BEGIN: begin
                thr_time[cmd.slot] <= cmd.now_ns;
                thr_flags[cmd.slot] <= cmd.lock_flags;
              end
              OP_CPU_END, OP_THR_END: begin
                from_cpu <= cmd.op == OP_CPU_END;
                now_q <= cmd.now_ns;
                state <= S_FETCH;
              end
              OP_READ: begin
                res.lock_class <= sel;
                if ({28'd0, sel} < NUM_TYPES) begin
                  res.total_time <= tot[sel];
                  res.event_count <= cnt[sel];
                  res.max_time <= mx[sel];
                end
              end
              default: ;
            endcase
            if (state == S_IDLE && cmd.op != OP_CPU_END && cmd.op != OP_THR_END)
              res.valid <= 1'b1;
          end
        end
        S_FETCH: begin
          dur <= now_q - start;
          ty <= type_of(fl);
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (dur[63]) begin
            res.status <= ST_NEGATIVE;
          end else begin
            res.status <= ST_ENDED;
            res.lock_class <= ty;
            tot[ty] <= tot[ty] + dur;
            cnt[ty] <= cnt[ty] + 64'd1;
            if (mx[ty] < dur) mx[ty] <= dur;
            res.total_time <= tot[ty] + dur;
            res.event_count <= cnt[ty] + 64'd1;
            res.max_time <= (mx[ty] < dur) ? dur : mx[ty];
          end
          res.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (res.valid && res.ready) begin
            res.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_valid_only_out: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> state == S_OUT) else $error("result shown outside output state");
  a_update_then_out: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |=> state == S_OUT && res.valid) else $error("update did not deliver");
  a_take_once: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready |=> !res.valid) else $error("result delivered twice");
`endif

endmodule

>>> hdl/lock_wait_latency_monitor.sv
// Lock wait latency monitor top level: a front end that matches begin and end events
// against the processor slots and the thread table, a two-entry command queue, and a
// back end that computes the wait and updates the nine per-type statistics. An event is
// accepted when the command queue is empty, and each result is offered in a register of
// its own; begins, refused ends and reads go straight to their result, while a matched
// end first passes through reading the start time, the subtract and then the statistics
// update. Two events can be taken back to back, after which the front waits for the queue
// to drain; the event rate is set by the back end, which handles one command at a time, and
// by how soon the result is taken. No clearing pass follows reset.
module lock_wait_latency_monitor import lwlm_pkg::*; (
  input logic clk,
  input logic rst,
  lwlm_event_if.sink events,
  lwlm_result_if.source results
);

  logic f_valid, q_full, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  lwlm_front u_front (
    .clk(clk), .rst(rst), .evt(events), .q_full(q_full),
    .cmd_valid(f_valid), .cmd(f_cmd)
  );

  lwlm_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_cmd(f_cmd), .full(q_full),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  lwlm_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd(q_cmd), .cmd_ready(q_ready),
    .res(results)
  );

endmodule
